### sv/ptts_pkg.sv
// Shared types and constants of the priority task table scheduler.
// Holds the item structs, mode codes, FSM states and the controller/datapath links.
// Depends on nothing; every other file of the block imports it.
package ptts_pkg;

	// Table geometry and derived widths.
	localparam int TABLE_DEPTH = 8;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// A task with this priority is never selected.
	localparam logic [7:0] PRIO_NEVER = 8'hFF;

	// Operation codes carried in the mode field.
	typedef enum logic [2:0] {
		MODE_CREATE = 3'd0,
		MODE_REMOVE = 3'd1,
		MODE_PAUSE  = 3'd2,
		MODE_RESUME = 3'd3,
		MODE_SELECT = 3'd4,
		MODE_CHARGE = 3'd5
	} mode_t;

	// One request item.
	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  task_id;
		logic [7:0]  task_priority;
		logic [2:0]  slot_index;
		logic [31:0] elapsed_ticks;
	} req_t;

	// One response item.
	typedef struct packed {
		logic        accepted;
		logic        found;
		logic [2:0]  chosen_slot;
		logic [7:0]  chosen_id;
		logic [7:0]  chosen_priority;
		logic [3:0]  entries_used;
		logic [31:0] run_total;
	} rsp_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic create;
		logic slot_op;
		logic remove_start;
		logic scan_init;
		logic scan_step;
		logic shift_step;
		logic shift_end;
		logic emit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0]       mode;
		logic             slot_ok;
		logic             scan_more;
		logic             shift_more;
		logic             out_free;
		logic [CNT_W-1:0] used;
	} dp_stat_t;

endpackage

### sv/ptts_datapath.sv
// Datapath of the priority task table scheduler: task table, scan and shift
// index, result registers and the response output register.
// Depends on ptts_pkg; driven by ptts_controller through ctl_cmd_t.
module ptts_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ptts_pkg::req_t    req,
	input  ptts_pkg::ctl_cmd_t cmd,
	output ptts_pkg::dp_stat_t stat,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ptts_pkg::rsp_t    rsp
);
	import ptts_pkg::*;

	// Task table.
	logic [7:0]  ids_q     [TABLE_DEPTH];
	logic [7:0]  prios_q   [TABLE_DEPTH];
	logic [31:0] times_q   [TABLE_DEPTH];
	logic        running_q [TABLE_DEPTH];
	logic [CNT_W-1:0] used_q;

	// Captured request, walk index and working result.
	req_t             req_q;
	logic [CNT_W-1:0] idx_q;
	logic [7:0]       best_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	logic             rsp_valid_q;

	logic [CNT_W-1:0] idx_next;
	logic [IDX_W-1:0] slot_idx;
	logic [IDX_W-1:0] used_idx;
	logic [IDX_W-1:0] walk_idx;
	logic [IDX_W-1:0] rd_addr;
	logic [7:0]       rd_id;
	logic [7:0]       rd_prio;
	logic [31:0]      rd_time;
	logic             rd_run;
	logic [31:0]      charged;
	logic             slot_ok;
	logic             has_room;
	logic             is_charge;
	logic             better;

	// Index arithmetic and the single table read port.
	always_comb begin
		idx_next  = idx_q + 1'b1;
		slot_idx  = IDX_W'(req_q.slot_index);
		used_idx  = used_q[IDX_W-1:0];
		walk_idx  = idx_q[IDX_W-1:0];
		slot_ok   = 32'(req_q.slot_index) < 32'(used_q);
		has_room  = 32'(used_q) < TABLE_DEPTH;
		is_charge = req_q.mode == MODE_CHARGE;
		if (cmd.shift_step) begin
			rd_addr = idx_next[IDX_W-1:0];
		end else if (cmd.scan_step) begin
			rd_addr = walk_idx;
		end else begin
			rd_addr = slot_idx;
		end
		rd_id   = ids_q[rd_addr];
		rd_prio = prios_q[rd_addr];
		rd_time = times_q[rd_addr];
		rd_run  = running_q[rd_addr];
		charged = rd_time + req_q.elapsed_ticks;
		better  = rd_run && (rd_prio < best_q);
	end

	// Status toward the controller.
	always_comb begin
		stat.mode       = req_q.mode;
		stat.slot_ok    = slot_ok;
		stat.scan_more  = idx_q < used_q;
		stat.shift_more = idx_next < used_q;
		stat.out_free   = !rsp_valid_q || !rsp_stall;
		stat.used       = used_q;
	end

	// Table payload: append on create, update on charge, move down on shift.
	always_ff @(posedge clk) begin
		if (cmd.create && has_room) begin
			ids_q[used_idx]   <= req_q.task_id;
			prios_q[used_idx] <= req_q.task_priority;
			times_q[used_idx] <= '0;
		end
		if (cmd.slot_op && slot_ok && is_charge) begin
			times_q[slot_idx] <= charged;
		end
		if (cmd.shift_step) begin
			ids_q[walk_idx]   <= rd_id;
			prios_q[walk_idx] <= rd_prio;
			times_q[walk_idx] <= rd_time;
		end
	end

	// Run flags and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				running_q[i] <= 1'b0;
			end
			used_q <= '0;
		end else begin
			if (cmd.create && has_room) begin
				running_q[used_idx] <= 1'b1;
				used_q              <= used_q + 1'b1;
			end
			if (cmd.slot_op && slot_ok && !is_charge) begin
				running_q[slot_idx] <= req_q.mode == MODE_RESUME;
			end
			if (cmd.shift_step) begin
				running_q[walk_idx] <= rd_run;
			end
			if (cmd.shift_end) begin
				running_q[walk_idx] <= 1'b0;
				used_q              <= used_q - 1'b1;
			end
		end
	end

	// Walk index over the table for select and remove.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.remove_start) begin
			idx_q <= CNT_W'(req_q.slot_index);
		end else if (cmd.scan_init) begin
			idx_q <= '0;
		end else if (cmd.scan_step || cmd.shift_step) begin
			idx_q <= idx_next;
		end
	end

	// Request capture and working result.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req;
			res_q  <= '0;
			best_q <= PRIO_NEVER;
		end
		if (cmd.create) begin
			res_q.accepted <= has_room;
		end
		if (cmd.slot_op && slot_ok) begin
			res_q.accepted  <= 1'b1;
			res_q.run_total <= is_charge ? charged : rd_time;
		end
		if (cmd.remove_start) begin
			res_q.accepted  <= 1'b1;
			res_q.run_total <= rd_time;
		end
		if (cmd.scan_init) begin
			res_q.accepted <= 1'b1;
		end
		if (cmd.scan_step && better) begin
			best_q                <= rd_prio;
			res_q.found           <= 1'b1;
			res_q.chosen_slot     <= 3'(walk_idx);
			res_q.chosen_id       <= rd_id;
			res_q.chosen_priority <= rd_prio;
			res_q.run_total       <= rd_time;
		end
	end

	// Finished result; the entry count is taken after the operation settles.
	always_comb begin
		rsp_d              = res_q;
		rsp_d.entries_used = 4'(used_q);
	end

	// Response register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### sv/ptts_controller.sv
// Controller of the priority task table scheduler: one state machine that
// sequences each item's table work and hands the result to the output register.
// Depends on ptts_pkg; drives ptts_datapath through ctl_cmd_t.
module ptts_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  ptts_pkg::dp_stat_t stat,
	output ptts_pkg::ctl_cmd_t cmd,
	output logic               idle
);
	import ptts_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		idle       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_next  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_next = ST_DONE;
				case (stat.mode)
					MODE_CREATE: begin
						cmd.create = 1'b1;
					end
					MODE_REMOVE: begin
						if (stat.slot_ok) begin
							cmd.remove_start = 1'b1;
							state_next       = ST_SHIFT;
						end
					end
					MODE_PAUSE, MODE_RESUME, MODE_CHARGE: begin
						cmd.slot_op = 1'b1;
					end
					MODE_SELECT: begin
						cmd.scan_init = 1'b1;
						state_next    = ST_SCAN;
					end
					default: begin
						// Unknown modes leave the cleared result as it is.
					end
				endcase
			end
			ST_SCAN: begin
				if (stat.scan_more) begin
					cmd.scan_step = 1'b1;
				end else begin
					state_next = ST_DONE;
				end
			end
			ST_SHIFT: begin
				if (stat.shift_more) begin
					cmd.shift_step = 1'b1;
				end else begin
					cmd.shift_end = 1'b1;
					state_next    = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.emit   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

### sv/priority_task_table_scheduler.sv
// Top level of the priority task table scheduler.
// Joins ptts_controller and ptts_datapath; depends on ptts_pkg.
//
// Usage: requests enter on req/req_valid/req_stall, responses leave on
// rsp/rsp_valid/rsp_stall; an item moves at a clock edge with valid high and
// stall low. Every request item yields exactly one response item.
// The block works on one request at a time; req_stall is low only while the
// controller is idle. Create, pause, resume, charge and unknown modes pass
// through the exec state straight to the done state, which loads the response
// register. Select walks the used entries one per cycle in the scan state.
// Remove moves the later entries down one per cycle in the shift state;
// a remove on a bad slot goes straight from exec to done. The next request
// can be accepted in the cycle after the response is loaded.
// The response register holds a finished item while rsp_stall is high; the
// controller waits with the next result until that register is free.
// Reset clears the fill count, the run flags, the controller state and the
// response valid flag; the table payload is written before it is ever read.
module priority_task_table_scheduler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ptts_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ptts_pkg::rsp_t rsp
);
	import ptts_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;
	logic     idle;

	ptts_controller u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.stat      (stat),
		.cmd       (cmd),
		.idle      (idle)
	);

	ptts_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Requests are taken only while the controller is idle.
	assign req_stall = !idle;

`ifndef SYNTHESIS
	// The fill count never passes the table depth.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stat.used) <= TABLE_DEPTH)
		else $error("table fill count above depth");

	// An accepted request blocks further requests in the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while another is in work");

	// A found task always comes with an accepted response.
	a_found_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |-> rsp.accepted)
		else $error("found without accepted");

	// A task with the never-run priority is never chosen.
	a_never_prio: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |-> (rsp.chosen_priority != PRIO_NEVER))
		else $error("task with never-run priority chosen");
`endif

endmodule

### verif/priority_task_table_scheduler_tb.sv
// Self-checking testbench for the priority task table scheduler.
// Predicts every response item from its own copy of the task table and checks them in order.
// Depends on ptts_pkg and the priority_task_table_scheduler top level.
module priority_task_table_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ptts_pkg::*;

	// Mode codes that the block must ignore.
	localparam logic [2:0] MODE_RSVD_A = 3'd6;
	localparam logic [2:0] MODE_RSVD_B = 3'd7;

	// Cycles allowed for the slowest operation to finish after the last response.
	localparam int TAIL_CYCLES = 4 * TABLE_DEPTH;

	// Scoreboard: keeps a shadow task table and the queue of predicted responses.
	class sched_scoreboard;
		logic [7:0]  task_ids   [TABLE_DEPTH];
		logic [7:0]  task_prios [TABLE_DEPTH];
		bit          running    [TABLE_DEPTH];
		logic [31:0] run_time   [TABLE_DEPTH];
		int unsigned used;
		rsp_t        pending_rsp[$];
		int          errors;

		function new();
			used = 0;
			errors = 0;
			foreach (running[i]) begin
				running[i] = 1'b0;
				task_ids[i] = '0;
				task_prios[i] = '0;
				run_time[i] = '0;
			end
		endfunction

		// Prints one line per mismatch and counts it.
		task report_mismatch(string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		// Applies one accepted request item to the shadow table and queues its response.
		function void predict_response(req_t r);
			rsp_t        e;
			bit          slot_ok;
			int unsigned s;
			logic [7:0]  best;
			e = '0;
			s = r.slot_index;
			slot_ok = (s < used);
			case (r.mode)
				MODE_CREATE: begin
					if (used < TABLE_DEPTH) begin
						task_ids[used] = r.task_id;
						task_prios[used] = r.task_priority;
						running[used] = 1'b1;
						run_time[used] = '0;
						used++;
						e.accepted = 1'b1;
					end
				end
				MODE_REMOVE: begin
					if (slot_ok) begin
						e.run_total = run_time[s];
						// Later entries move down by one slot.
						for (int i = s; i + 1 < used; i++) begin
							task_ids[i] = task_ids[i + 1];
							task_prios[i] = task_prios[i + 1];
							running[i] = running[i + 1];
							run_time[i] = run_time[i + 1];
						end
						used--;
						running[used] = 1'b0;
						e.accepted = 1'b1;
					end
				end
				MODE_PAUSE, MODE_RESUME: begin
					if (slot_ok) begin
						running[s] = (r.mode == MODE_RESUME);
						e.run_total = run_time[s];
						e.accepted = 1'b1;
					end
				end
				MODE_SELECT: begin
					// Strictly lower priority wins, so ties stay with the lowest slot.
					best = PRIO_NEVER;
					e.accepted = 1'b1;
					for (int i = 0; i < used; i++) begin
						if (running[i] && task_prios[i] < best) begin
							best = task_prios[i];
							e.chosen_slot = 3'(i);
							e.found = 1'b1;
						end
					end
					if (e.found) begin
						e.chosen_id = task_ids[e.chosen_slot];
						e.chosen_priority = task_prios[e.chosen_slot];
						e.run_total = run_time[e.chosen_slot];
					end
				end
				MODE_CHARGE: begin
					if (slot_ok) begin
						run_time[s] = run_time[s] + r.elapsed_ticks;
						e.run_total = run_time[s];
						e.accepted = 1'b1;
					end
				end
				default: begin
				end
			endcase
			e.entries_used = 4'(used);
			pending_rsp.push_back(e);
		endfunction

		// Compares one accepted response item with the oldest prediction.
		task check_response(rsp_t got);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("response item with none expected: %h", got));
			end else begin
				e = pending_rsp.pop_front();
				if (got.accepted !== e.accepted)
					report_mismatch($sformatf("accepted got %b exp %b", got.accepted, e.accepted));
				if (got.found !== e.found)
					report_mismatch($sformatf("found got %b exp %b", got.found, e.found));
				if (got.chosen_slot !== e.chosen_slot)
					report_mismatch($sformatf("chosen_slot got %0d exp %0d",
						got.chosen_slot, e.chosen_slot));
				if (got.chosen_id !== e.chosen_id)
					report_mismatch($sformatf("chosen_id got %h exp %h",
						got.chosen_id, e.chosen_id));
				if (got.chosen_priority !== e.chosen_priority)
					report_mismatch($sformatf("chosen_priority got %h exp %h",
						got.chosen_priority, e.chosen_priority));
				if (got.entries_used !== e.entries_used)
					report_mismatch($sformatf("entries_used got %0d exp %0d",
						got.entries_used, e.entries_used));
				if (got.run_total !== e.run_total)
					report_mismatch($sformatf("run_total got %h exp %h",
						got.run_total, e.run_total));
			end
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	sched_scoreboard sb = new();

	int recv_stall_pct = 0;
	int hold_left = 0;

	priority_task_table_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Free-running clock, 8 ns period.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#(5_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Response side: checks each accepted item, then picks the next stall value.
	// A requested long hold-off is counted down here, one cycle at a time.
	initial begin
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				sb.check_response(rsp);
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	function automatic req_t mk(logic [2:0] mode, logic [7:0] id, logic [7:0] prio,
			logic [2:0] slot, logic [31:0] ticks);
		req_t r;
		r.mode = mode;
		r.task_id = id;
		r.task_priority = prio;
		r.slot_index = slot;
		r.elapsed_ticks = ticks;
		return r;
	endfunction

	// Random item, mostly aimed at slots that exist so the table state moves.
	function automatic req_t random_item();
		req_t r;
		int   pick;
		r.task_id = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 10) r.task_priority = PRIO_NEVER;
		else if (pick < 20) r.task_priority = 8'($urandom_range(0, 3));
		else r.task_priority = 8'($urandom);
		if (sb.used > 0 && $urandom_range(0, 99) < 85)
			r.slot_index = 3'($urandom_range(0, sb.used - 1));
		else
			r.slot_index = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		if (pick < 20) r.elapsed_ticks = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
		else if (pick < 30) r.elapsed_ticks = 32'($urandom_range(0, 15));
		else r.elapsed_ticks = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 18) r.mode = MODE_CREATE;
		else if (pick < 34) r.mode = MODE_REMOVE;
		else if (pick < 46) r.mode = MODE_PAUSE;
		else if (pick < 58) r.mode = MODE_RESUME;
		else if (pick < 78) r.mode = MODE_SELECT;
		else if (pick < 96) r.mode = MODE_CHARGE;
		else if (pick < 98) r.mode = MODE_RSVD_A;
		else r.mode = MODE_RSVD_B;
		return r;
	endfunction

	// Offers one request item and returns in the cycle it is accepted.
	task automatic send_item(req_t r);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.predict_response(r);
	endtask

	// Leaves the request channel idle for a random number of cycles.
	task automatic idle_gap(int pct);
		int n;
		n = 0;
		while (n < 40 && $urandom_range(0, 99) < pct) n++;
		if (n > 0) begin
			req_valid <= 1'b0;
			req <= random_item();
			repeat (n) @(posedge clk);
		end
	endtask

	// Stops offering items until every predicted response item has arrived.
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_rsp.size() != 0);
	endtask

	task automatic run_phase(int n, int send_pct, int recv_pct);
		recv_stall_pct = recv_pct;
		repeat (n) begin
			send_item(random_item());
			idle_gap(send_pct);
		end
		drain();
	endtask

	// Main sequence: reset, directed items, then random phases.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Empty table: select finds nothing, every slot is out of range.
		send_item(mk(MODE_SELECT, 8'h00, 8'h00, 3'd0, 32'h0));
		send_item(mk(MODE_REMOVE, 8'hFF, 8'hFF, 3'd0, 32'hFFFF_FFFF));
		send_item(mk(MODE_PAUSE,  8'h00, 8'h00, 3'd0, 32'h0));
		send_item(mk(MODE_RESUME, 8'hFF, 8'hFF, 3'd7, 32'h0));
		send_item(mk(MODE_CHARGE, 8'h00, 8'h00, 3'd3, 32'hFFFF_FFFF));
		// Unknown modes change nothing.
		send_item(mk(MODE_RSVD_A, 8'hFF, 8'hFF, 3'd7, 32'hFFFF_FFFF));
		send_item(mk(MODE_RSVD_B, 8'h5A, 8'h00, 3'd0, 32'h0));
		// A task at the never-run priority is not selected.
		send_item(mk(MODE_CREATE, 8'hFF, PRIO_NEVER, 3'd0, 32'h0));
		send_item(mk(MODE_SELECT, 8'h00, 8'h00, 3'd0, 32'h0));
		// Fill the table, with equal priorities in several slots.
		send_item(mk(MODE_CREATE, 8'h00, 8'h00, 3'd7, 32'h0));
		send_item(mk(MODE_CREATE, 8'h11, 8'h40, 3'd0, 32'h0));
		send_item(mk(MODE_CREATE, 8'h22, 8'h40, 3'd0, 32'h0));
		send_item(mk(MODE_CREATE, 8'h33, 8'h80, 3'd0, 32'h0));
		send_item(mk(MODE_CREATE, 8'h44, 8'hFE, 3'd0, 32'h0));
		send_item(mk(MODE_CREATE, 8'h55, 8'h01, 3'd0, 32'h0));
		send_item(mk(MODE_CREATE, 8'h66, 8'h00, 3'd0, 32'h0));
		// Table full: create is refused.
		send_item(mk(MODE_CREATE, 8'h77, 8'h00, 3'd0, 32'h0));
		send_item(mk(MODE_SELECT, 8'h00, 8'h00, 3'd0, 32'h0));
		send_item(mk(MODE_PAUSE,  8'h00, 8'h00, 3'd1, 32'h0));
		send_item(mk(MODE_SELECT, 8'h00, 8'h00, 3'd0, 32'h0));
		// Run time wraps past the top of its range.
		send_item(mk(MODE_CHARGE, 8'h00, 8'h00, 3'd7, 32'hFFFF_FFFF));
		send_item(mk(MODE_CHARGE, 8'h00, 8'h00, 3'd7, 32'h0000_0002));
		// Remove the last slot, then the first with a full shift, then one past the end.
		send_item(mk(MODE_REMOVE, 8'h00, 8'h00, 3'd7, 32'h0));
		send_item(mk(MODE_REMOVE, 8'h00, 8'h00, 3'd0, 32'h0));
		send_item(mk(MODE_REMOVE, 8'h00, 8'h00, 3'd6, 32'h0));
		send_item(mk(MODE_RESUME, 8'h00, 8'h00, 3'd0, 32'h0));
		send_item(mk(MODE_SELECT, 8'h00, 8'h00, 3'd0, 32'h0));
		drain();

		// Long receiver hold-off while items keep coming, so the block backs up.
		hold_left = 300;
		run_phase(190, 0, 0);
		run_phase(190, 62, 0);
		run_phase(190, 0, 62);
		run_phase(190, 11, 11);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
